[hw/rtl/poly_eval_with_derivatives_assert.svh]
`ifndef POLY_EVAL_WITH_DERIVATIVES_ASSERT_SVH
`define POLY_EVAL_WITH_DERIVATIVES_ASSERT_SVH

// Check cons in the same cycle whenever ante holds; uses the module's clk and rst.
`define PEWD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pewd assertion failed");

// Check cons in the cycle after ante holds.
`define PEWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pewd assertion failed");

`endif

[hw/rtl/pewd_pkg.sv]
package pewd_pkg;

  localparam int COEFF_COUNT = 8;
  localparam int NREGS       = 8;
  localparam int N_USED      = (COEFF_COUNT > NREGS) ? NREGS :
                               ((COEFF_COUNT < 1) ? 1 : COEFF_COUNT);
  localparam int STEPS       = N_USED - 1;

  localparam int LANES      = 4;
  localparam int COEF_W     = 64;
  localparam int WGT_W      = 8;
  localparam int WCOEF_W    = COEF_W + WGT_W;
  localparam int TIME_W     = 32;
  localparam int TIME_FRAC  = 16;
  localparam int OUT_W      = 64;
  localparam int ACC_W      = 320;
  localparam int LIMB_W     = 32;
  localparam int LIMBS      = ACC_W / LIMB_W;
  localparam int CFG_IDX_W  = 4;
  localparam int REG_IDX_W  = $clog2(NREGS);

  localparam int FRAC_SHIFT = TIME_FRAC * STEPS;
  localparam int HI_W       = ACC_W - FRAC_SHIFT - OUT_W + 1;

  typedef logic [ACC_W-1:0]          acc_t;
  typedef acc_t [LANES-1:0]          lanes_t;
  typedef logic [COEF_W-1:0]         coef_t;
  typedef coef_t [NREGS-1:0]         coef_arr_t;
  typedef logic [WCOEF_W-1:0]        wcoef_t;
  typedef wcoef_t [NREGS-1:0]        wrow_t;
  typedef wrow_t [LANES-1:0]         wtab_t;
  typedef logic [OUT_W-1:0]          out_t;
  typedef out_t [LANES-1:0]          outs_t;

  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] t;
    lanes_t            acc;
  } stage_t;

  localparam acc_t ROUND_ADD = acc_t'(1) << (FRAC_SHIFT - 1);
  localparam out_t SAT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_t SAT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  // k, k(k-1), k(k-1)(k-2) for derivative orders one to three
  function automatic logic [WGT_W-1:0] deriv_weight(input int d, input int k);
    int w;
    w = 1;
    if (k < d) begin
      w = 0;
    end else begin
      for (int i = 0; i < d; i++) begin
        w = w * (k - i);
      end
    end
    return WGT_W'(w);
  endfunction

endpackage

[hw/rtl/pewd_coef_bank.sv]
module pewd_coef_bank (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pewd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pewd_pkg::COEF_W-1:0]  cfg_data,
  output pewd_pkg::coef_arr_t          coef,
  output pewd_pkg::wtab_t              wcoef
);
  import pewd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NREGS))) begin
      coef[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // weighted copies are registered, so they update in the cycle after the raw registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wcoef <= '0;
    end else begin
      for (int d = 0; d < LANES; d++) begin
        for (int k = 0; k < NREGS; k++) begin
          wcoef[d][k] <= WCOEF_W'($signed(coef[k]))
                         * {{(WCOEF_W-WGT_W){1'b0}}, deriv_weight(d, k)};
        end
      end
    end
  end

endmodule

[hw/rtl/pewd_horner_step.sv]
`include "poly_eval_with_derivatives_assert.svh"

module pewd_horner_step (
  input  logic             clk,
  input  logic             rst,
  input  pewd_pkg::stage_t up,
  output logic             up_ready,
  input  pewd_pkg::lanes_t addend,
  output pewd_pkg::stage_t dn,
  input  logic             dn_ready
);
  import pewd_pkg::*;

  logic                      vld_a;
  logic [TIME_W-1:0]         t_a;
  logic [2*LIMB_W-1:0]       prod_a [LANES][LIMBS];
  logic                      en_a;

  logic                      vld_b;
  logic [TIME_W-1:0]         t_b;
  lanes_t                    acc_b;
  lanes_t                    acc_b_next;
  logic                      en_b;

  lanes_t                    even;
  lanes_t                    odd;

  assign en_b     = !vld_b || dn_ready;
  assign en_a     = !vld_a || en_b;
  assign up_ready = en_a;

  // stage A: one 32x32 product per limb and lane
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en_a) begin
      vld_a <= up.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      t_a <= up.t;
      for (int l = 0; l < LANES; l++) begin
        for (int b = 0; b < LIMBS; b++) begin
          prod_a[l][b] <= up.acc[l][b*LIMB_W +: LIMB_W] * up.t;
        end
      end
    end
  end

  // even and odd limb products never overlap, so each group packs side by side
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int h = 0; h < LIMBS/2; h++) begin
        even[l][h*2*LIMB_W +: 2*LIMB_W] = prod_a[l][2*h];
        odd[l][h*2*LIMB_W +: 2*LIMB_W]  = prod_a[l][2*h+1];
      end
      acc_b_next[l] = even[l] + {odd[l][ACC_W-LIMB_W-1:0], {LIMB_W{1'b0}}} + addend[l];
    end
  end

  // stage B: fold partial products and the next scaled coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (en_b) begin
      vld_b <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      t_b   <= t_a;
      acc_b <= acc_b_next;
    end
  end

  assign dn = '{vld: vld_b, t: t_b, acc: acc_b};

  `PEWD_ASSERT_NEXT(a_stage_b_follows_a, en_b, vld_b == $past(vld_a))
  `PEWD_ASSERT_NEXT(a_stage_b_holds, vld_b && !dn_ready, $stable(acc_b) && $stable(t_b))

endmodule

[hw/rtl/pewd_round_sat.sv]
`include "poly_eval_with_derivatives_assert.svh"

module pewd_round_sat (
  input  logic             clk,
  input  logic             rst,
  input  pewd_pkg::stage_t up,
  output logic             up_ready,
  output logic             out_vld,
  input  logic             out_rdy,
  output pewd_pkg::outs_t  res,
  output logic             ovf
);
  import pewd_pkg::*;

  logic        vld_r;
  lanes_t      rnd_r;
  logic        en_r;
  logic        en_o;

  outs_t       res_next;
  logic        ovf_next;
  logic [HI_W-1:0] hi [LANES];
  logic [LANES-1:0] fits;

  assign en_o     = !out_vld || out_rdy;
  assign en_r     = !vld_r || en_o;
  assign up_ready = en_r;

  // add half an output step, ties go upward
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (en_r) begin
      vld_r <= up.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_r) begin
      for (int l = 0; l < LANES; l++) begin
        rnd_r[l] <= up.acc[l] + ROUND_ADD;
      end
    end
  end

  // drop the fraction, clamp when the bits above do not all match the sign
  always_comb begin
    ovf_next = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      hi[l]   = rnd_r[l][ACC_W-1:FRAC_SHIFT+OUT_W-1];
      fits[l] = (&hi[l]) || !(|hi[l]);
      if (fits[l]) begin
        res_next[l] = rnd_r[l][FRAC_SHIFT +: OUT_W];
      end else begin
        res_next[l] = rnd_r[l][ACC_W-1] ? SAT_MIN : SAT_MAX;
      end
      ovf_next = ovf_next || !fits[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en_o) begin
      out_vld <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      res <= res_next;
      ovf <= ovf_next;
    end
  end

  `PEWD_ASSERT_NOW(a_ovf_has_clamp, out_vld && ovf,
    res[0] == SAT_MAX || res[0] == SAT_MIN || res[1] == SAT_MAX || res[1] == SAT_MIN ||
    res[2] == SAT_MAX || res[2] == SAT_MIN || res[3] == SAT_MAX || res[3] == SAT_MIN)

endmodule

[hw/rtl/poly_eval_with_derivatives.sv]
// Samples a segment polynomial of up to degree seven and returns position, velocity,
// acceleration and jerk (signed Q32.32, saturated, overflow in tuser) for each time word
// (unsigned Q16.16). One time word is taken every clock while s_axis_tready is high. The
// path holds 2*(COEFF_COUNT-1)+2 register stages (16 with eight coefficients): each Horner
// step is a limb-product stage and a fold stage, all four derivatives run side by side,
// and two final stages round and clamp. Every stage holds its own valid bit, so a stalled
// output only backs up as far as the pipeline is full. The user must write coefficients
// through the cfg port only while no sample is in flight; the block does not enforce it.
// A write lands in the raw coefficient registers first, then in the weighted copies.
module poly_eval_with_derivatives (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pewd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pewd_pkg::COEF_W-1:0]    cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pewd_pkg::TIME_W-1:0]    s_axis_tdata,   // [31:0] sample_time
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [63:0] position, [127:64] velocity, [191:128] acceleration, [255:192] jerk
  output logic [pewd_pkg::LANES*pewd_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser    // [0] overflow
);
  import pewd_pkg::*;

  coef_arr_t coef;
  wtab_t     wcoef;
  stage_t    chain [STEPS+1];
  logic      rdy   [STEPS+1];
  lanes_t    addend [STEPS];
  lanes_t    init;
  outs_t     res;

  pewd_coef_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef),
    .wcoef     (wcoef)
  );

  // Horner starts from the top coefficient; only the position lane has one there
  always_comb begin
    init    = '0;
    init[0] = acc_t'($signed(coef[STEPS]));
  end

  assign chain[0]      = '{vld: s_axis_tvalid, t: s_axis_tdata, acc: init};
  assign s_axis_tready = rdy[0];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    for (genvar d = 0; d < LANES; d++) begin : g_lane
      localparam int K = d + STEPS - 1 - i;
      if (K < N_USED) begin : g_term
        assign addend[i][d] = acc_t'($signed(wcoef[d][K])) << (TIME_FRAC * (i + 1));
      end else begin : g_none
        assign addend[i][d] = '0;
      end
    end

    pewd_horner_step u_step (
      .clk      (clk),
      .rst      (rst),
      .up       (chain[i]),
      .up_ready (rdy[i]),
      .addend   (addend[i]),
      .dn       (chain[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  pewd_round_sat u_round (
    .clk      (clk),
    .rst      (rst),
    .up       (chain[STEPS]),
    .up_ready (rdy[STEPS]),
    .out_vld  (m_axis_tvalid),
    .out_rdy  (m_axis_tready),
    .res      (res),
    .ovf      (m_axis_tuser)
  );

  assign m_axis_tdata = res;

endmodule
